/* rtl/lkv_pkg.sv */
package lkv_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 31;
    localparam int CAP_W      = 5;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESP,
        ST_UPDATE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic cnt_clr;   // restart the entry counter
        logic scan_step; // pass 1: match / victim / free search
        logic decide;    // pick target, evict, fetch hit data
        logic rsp_load;  // load the result register
        logic upd_step;  // pass 2: age rewrite
        logic commit;    // write data; on an insert also key, mark valid
    } cmd_t;

    typedef struct packed {
        logic is_set;
        logic found;
        logic cnt_last;
        logic out_busy;
    } status_t;

endpackage

/* rtl/lkv_ctrl.sv */
module lkv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lkv_pkg::status_t sts,
    output lkv_pkg::cmd_t    cmd
);

    lkv_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = lkv_pkg::ST_DECIDE;
                end
            end
            lkv_pkg::ST_DECIDE: begin
                cmd.decide  = 1'b1;
                cmd.cnt_clr = 1'b1;
                if (sts.is_set == lkv_pkg::ACT_SET) begin
                    state_next = lkv_pkg::ST_UPDATE;
                end else begin
                    state_next = lkv_pkg::ST_RESP;
                end
            end
            lkv_pkg::ST_RESP: begin
                if (!sts.out_busy) begin
                    cmd.rsp_load = 1'b1;
                    state_next   = sts.found ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_IDLE;
                end
            end
            lkv_pkg::ST_UPDATE: begin
                cmd.upd_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = lkv_pkg::ST_COMMIT;
                end
            end
            lkv_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = lkv_pkg::ST_IDLE;
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lkv_dpath.sv */
module lkv_dpath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lkv_pkg::cmd_t                  cmd,
    output lkv_pkg::status_t               sts,
    input  logic                           req_action,
    input  logic [lkv_pkg::KEY_W-1:0]      req_key,
    input  logic [lkv_pkg::VAL_W-1:0]      req_value,
    input  logic                           cfg_valid,
    input  logic [lkv_pkg::CAP_W-1:0]      cfg_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           rsp_hit,
    output logic [lkv_pkg::VAL_W-1:0]      rsp_value
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    // entry stores
    logic [lkv_pkg::KEY_W-1:0] key_mem  [MAX_ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] data_mem [MAX_ENTRIES];
    logic [AW-1:0]             age_mem  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]             count_reg;
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;

    // request
    logic                      set_reg;
    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] val_reg;

    // sweep counter and read pipeline
    logic [CW-1:0]             cnt_reg;
    logic                      ev_vld_reg;
    logic [AW-1:0]             ev_idx_reg;
    logic [lkv_pkg::KEY_W-1:0] key_rd_reg;
    logic [AW-1:0]             age_rd_reg;
    logic [lkv_pkg::VAL_W-1:0] data_rd_reg;

    // search results
    logic          found_reg, vic_found_reg, free_found_reg;
    logic [AW-1:0] match_idx_reg, vic_idx_reg, free_idx_reg;
    logic [AW-1:0] match_age_reg, vic_age_reg;

    // pass 2 setup
    logic          ins_mode_reg;
    logic [AW-1:0] target_reg;
    logic [AW-1:0] thr_reg;

    // result register
    logic                      m_valid_reg;
    logic                      m_hit_reg;
    logic [lkv_pkg::VAL_W-1:0] m_data_reg;

    logic [EW-1:0] cap_ext, eff_cap;
    logic          full;
    logic          step;
    logic          rd_issue;
    logic [AW-1:0] addr;
    logic [AW-1:0] slot;
    logic          ev_valid;
    logic          bump;
    logic [AW-1:0] age_new;

    assign cap_ext = EW'(capacity_reg);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(MAX_ENTRIES)) begin
            eff_cap = EW'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign full = EW'(count_reg) >= eff_cap;

    assign step     = cmd.scan_step | cmd.upd_step;
    assign rd_issue = step && (cnt_reg < CW'(MAX_ENTRIES));
    assign addr     = cnt_reg[AW-1:0];
    assign ev_valid = valid_reg[ev_idx_reg];

    // lowest free slot after a possible eviction
    always_comb begin
        if (full) begin
            slot = (free_found_reg && free_idx_reg < vic_idx_reg) ? free_idx_reg : vic_idx_reg;
        end else begin
            slot = free_idx_reg;
        end
    end

    // insert ages every valid entry; touch ages only those younger than the hit
    assign bump    = ev_valid && (ins_mode_reg || age_rd_reg < thr_reg);
    assign age_new = (ev_idx_reg == target_reg) ? '0 :
                     bump ? AW'(age_rd_reg + 1'b1) : age_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            set_reg <= req_action;
            key_reg <= req_key;
            val_reg <= req_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            ev_vld_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (step && cnt_reg != CW'(MAX_ENTRIES)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            ev_vld_reg <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            key_rd_reg <= key_mem[addr];
            age_rd_reg <= age_mem[addr];
            ev_idx_reg <= addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_step && ev_vld_reg) begin
            age_mem[ev_idx_reg] <= age_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && set_reg == lkv_pkg::ACT_SET) begin
            data_mem[target_reg] <= val_reg;
            if (ins_mode_reg) begin
                key_mem[target_reg] <= key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            data_rd_reg <= data_mem[match_idx_reg];
        end
    end

    // pass 1 search
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            found_reg      <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan_step && ev_vld_reg) begin
            if (!found_reg && ev_valid && key_rd_reg == key_reg) begin
                found_reg     <= 1'b1;
                match_idx_reg <= ev_idx_reg;
                match_age_reg <= age_rd_reg;
            end
            if (ev_valid && (!vic_found_reg || age_rd_reg > vic_age_reg)) begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= ev_idx_reg;
                vic_age_reg   <= age_rd_reg;
            end
            if (!ev_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= ev_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            ins_mode_reg <= !found_reg;
            target_reg   <= found_reg ? match_idx_reg : slot;
            thr_reg      <= match_age_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (cmd.decide && set_reg == lkv_pkg::ACT_SET && !found_reg && full
                     && vic_found_reg) begin
            valid_reg[vic_idx_reg] <= 1'b0;
            count_reg              <= count_reg - 1'b1;
        end else if (cmd.commit && set_reg == lkv_pkg::ACT_SET && ins_mode_reg) begin
            valid_reg[target_reg] <= 1'b1;
            count_reg             <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.rsp_load) begin
            m_valid_reg <= 1'b1;
        end else if (rsp_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rsp_load) begin
            m_hit_reg  <= found_reg;
            m_data_reg <= found_reg ? data_rd_reg : '0;
        end
    end

    assign rsp_valid = m_valid_reg;
    assign rsp_hit   = m_hit_reg;
    assign rsp_value = m_data_reg;

    assign sts.is_set   = set_reg;
    assign sts.found    = found_reg;
    assign sts.cnt_last = (cnt_reg == CW'(MAX_ENTRIES));
    assign sts.out_busy = m_valid_reg && !rsp_ready;

endmodule

/* rtl/lru_key_value_cache.sv */
// Fully associative key/value cache with least-recently-used replacement.
// A get request (s_tuser = 0) returns one result: m_tuser is the hit flag and
// m_tdata the stored value, zero on a miss. A set request (s_tuser = 1)
// updates a present key or inserts a new one, evicting the least recent entry
// once the count reaches the capacity register; it returns no result.
// Capacity is written through cfg_valid/cfg_data; the user must write it only while
// the cache is idle, which the block itself does not enforce; 0 acts as 1 and values
// above MAX_ENTRIES act as MAX_ENTRIES. One request at a time: the single key/age
// memory port is swept once to search and, for a set or a get hit, once more to
// re-rank. A pending result does not block the next request until that request's
// own result is ready.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request: tdata = {value[30:0], key[31:0]} (key at bit 0), tuser = action
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lkv_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    // result: tdata = read_value[30:0], zero filled; tuser = hit
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lkv_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser,
    // capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_data
);

    lkv_pkg::cmd_t             cmd;
    lkv_pkg::status_t          sts;
    logic [lkv_pkg::VAL_W-1:0] rsp_value;

    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lkv_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .req_action (s_tuser),
        .req_key    (s_tdata[lkv_pkg::KEY_W-1:0]),
        .req_value  (s_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .rsp_valid  (m_tvalid),
        .rsp_ready  (m_tready),
        .rsp_hit    (m_tuser),
        .rsp_value  (rsp_value)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = lkv_pkg::M_TDATA_W'(rsp_value);

endmodule
